### design/bcmd_pkg.sv
// Shared types and constants for the battery cell min/max diagnostics block.
package bcmd_pkg;

    localparam int VOLT_W  = 16;
    localparam int INDEX_W = 4;
    localparam int CFG_W   = 8;

    localparam logic [VOLT_W-1:0] VOLT_MAX_VAL = '1;
    localparam logic [VOLT_W-1:0] VOLT_MIN_VAL = '0;

    localparam logic [CFG_W-1:0] ERROR_STEP_RST  = 8'd10;
    localparam logic [CFG_W-1:0] ERROR_LIMIT_RST = 8'd100;

    // Register index as decoded from paddr[2].
    localparam logic [0:0] REG_ERROR_STEP  = 1'b0;
    localparam logic [0:0] REG_ERROR_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_FLAWLESS = 2'd0,
        STATUS_ERROR    = 2'd1,
        STATUS_EXCL_A   = 2'd2,
        STATUS_EXCL_B   = 2'd3
    } module_status_t;

    typedef struct packed {
        logic [CFG_W-1:0] error_step;
        logic [CFG_W-1:0] error_limit;
    } cfg_t;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_voltage;
        logic [1:0]        module_status;
        logic              last_cell;
        logic              last_module;
        logic              stop_in;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] module_index;
        logic [VOLT_W-1:0]  module_min;
        logic [VOLT_W-1:0]  module_max;
        logic               pack_done;
        logic [VOLT_W-1:0]  pack_min;
        logic [VOLT_W-1:0]  pack_max;
        logic               pack_error;
        logic               shutdown;
    } result_t;

endpackage

### design/bcmd_cfg.sv
// APB register file holding the error timer step and limit.
module bcmd_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bcmd_pkg::cfg_t     cfg
);

    logic [bcmd_pkg::CFG_W-1:0] step_reg;
    logic [bcmd_pkg::CFG_W-1:0] limit_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= bcmd_pkg::ERROR_STEP_RST;
            limit_reg <= bcmd_pkg::ERROR_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                bcmd_pkg::REG_ERROR_STEP:  step_reg  <= pwdata[bcmd_pkg::CFG_W-1:0];
                bcmd_pkg::REG_ERROR_LIMIT: limit_reg <= pwdata[bcmd_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            bcmd_pkg::REG_ERROR_STEP:  prdata = {24'd0, step_reg};
            bcmd_pkg::REG_ERROR_LIMIT: prdata = {24'd0, limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.error_step  = step_reg;
    assign cfg.error_limit = limit_reg;

endmodule

### design/bcmd_datapath.sv
// Running module and pack statistics, error timer, and result formation.
module bcmd_datapath #(
    parameter int MAX_MODULES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  bcmd_pkg::item_t     item,
    input  bcmd_pkg::cfg_t      cfg,
    output bcmd_pkg::result_t   result
);

    localparam int CNT_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_MODULES - 1);

    logic [bcmd_pkg::VOLT_W-1:0] cell_min_reg, cell_min_next;
    logic [bcmd_pkg::VOLT_W-1:0] cell_max_reg, cell_max_next;
    logic [bcmd_pkg::VOLT_W-1:0] pack_min_reg, pack_min_next;
    logic [bcmd_pkg::VOLT_W-1:0] pack_max_reg, pack_max_next;
    logic                        pack_err_reg, pack_err_next;
    logic [bcmd_pkg::CFG_W-1:0]  timer_reg, timer_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [bcmd_pkg::CFG_W:0]    timer_sum;
    logic [bcmd_pkg::CFG_W-1:0]  timer_sat;
    logic                        flawless;

    assign flawless = (item.module_status == bcmd_pkg::STATUS_FLAWLESS);

    always_comb
    begin
        cell_min_next = (item.cell_voltage < cell_min_reg) ? item.cell_voltage : cell_min_reg;
        cell_max_next = (item.cell_voltage > cell_max_reg) ? item.cell_voltage : cell_max_reg;

        pack_min_next = (flawless && (cell_min_next < pack_min_reg)) ? cell_min_next
                                                                       : pack_min_reg;
        pack_max_next = (flawless && (cell_max_next > pack_max_reg)) ? cell_max_next
                                                                       : pack_max_reg;
        pack_err_next = pack_err_reg | (item.module_status == bcmd_pkg::STATUS_ERROR);

        // The timer saturates at the limit, also when the limit was lowered below it.
        timer_sum  = {1'b0, timer_reg} + {1'b0, cfg.error_step};
        timer_sat  = (timer_sum > {1'b0, cfg.error_limit}) ? cfg.error_limit
                                                             : timer_sum[bcmd_pkg::CFG_W-1:0];
        timer_next = pack_err_next ? timer_sat : '0;
    end

    always_comb
    begin
        result.module_index = bcmd_pkg::INDEX_W'(cnt_reg);
        result.module_min   = cell_min_next;
        result.module_max   = cell_max_next;
        result.pack_done    = item.last_module;
        result.pack_min     = item.last_module ? pack_min_next : '0;
        result.pack_max     = item.last_module ? pack_max_next : '0;
        result.pack_error   = item.last_module & pack_err_next;
        result.shutdown     = item.last_module &
                              (item.stop_in | (timer_next >= cfg.error_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_min_reg <= bcmd_pkg::VOLT_MAX_VAL;
            cell_max_reg <= bcmd_pkg::VOLT_MIN_VAL;
            pack_min_reg <= bcmd_pkg::VOLT_MAX_VAL;
            pack_max_reg <= bcmd_pkg::VOLT_MIN_VAL;
            pack_err_reg <= 1'b0;
            timer_reg    <= '0;
            cnt_reg      <= '0;
        end
        else if (step_en)
        begin
            if (!item.last_cell)
            begin
                cell_min_reg <= cell_min_next;
                cell_max_reg <= cell_max_next;
            end
            else
            begin
                cell_min_reg <= bcmd_pkg::VOLT_MAX_VAL;
                cell_max_reg <= bcmd_pkg::VOLT_MIN_VAL;
                if (item.last_module)
                begin
                    timer_reg    <= timer_next;
                    pack_min_reg <= bcmd_pkg::VOLT_MAX_VAL;
                    pack_max_reg <= bcmd_pkg::VOLT_MIN_VAL;
                    pack_err_reg <= 1'b0;
                    cnt_reg      <= '0;
                end
                else
                begin
                    pack_min_reg <= pack_min_next;
                    pack_max_reg <= pack_max_next;
                    pack_err_reg <= pack_err_next;
                    cnt_reg      <= (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

### design/battery_cell_minmax_diag_core.sv
// Top level of the battery cell min/max diagnostics block.
//
// Usage: cell voltages enter on the slave stream, one request per cell, module
// after module. s_tdata carries the voltage, s_tlast marks the last cell of a
// module, and s_tuser carries the module status, the last-module flag and the
// external stop input. At every module end one request leaves on the master
// stream with the module index and its min/max; m_tlast marks the pack end,
// where the pack min/max, pack error and emergency stop are also valid.
// Error step and error limit are set through the APB port while idle.
// A module's last cell is first captured in the input register; its result is
// loaded into the result register, which drives m_tvalid, once there is space.
// Throughput is one cell per cycle unless a module end waits for the result
// register; the combinational compare-and-update path between registers sets it.
// When the receiver stalls, the result register holds its request and s_tready
// drops once a cell that ends a module waits in the input register; cells that
// end no module keep flowing as long as they do not need the result register.
// Reset clears all running statistics, the module counter, the error timer and
// both valid flags, and loads the registers with step 10 and limit 100.
module battery_cell_minmax_diag_core #(
    parameter int MAX_MODULES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] cell_voltage
    input  logic        s_tlast,   // last_cell
    input  logic [3:0]  s_tuser,   // [1:0] module_status, [2] last_module, [3] stop_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] module_index, [19:4] module_min,
                                   // [35:20] module_max, [51:36] pack_min,
                                   // [67:52] pack_max, [71:68] zero
    output logic        m_tlast,   // pack_done
    output logic [1:0]  m_tuser,   // [0] pack_error, [1] shutdown
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bcmd_pkg::cfg_t    cfg;
    bcmd_pkg::item_t   item_reg;
    bcmd_pkg::result_t res_comb;
    bcmd_pkg::result_t res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              out_space;
    logic              advance;

    bcmd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcmd_datapath #(
        .MAX_MODULES (MAX_MODULES)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res_comb)
    );

    // A cell that ends no module never needs the result register.
    assign out_space = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!item_reg.last_cell || out_space);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_space)
            begin
                out_valid_reg <= advance && item_reg.last_cell;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.cell_voltage  <= s_tdata;
            item_reg.module_status <= s_tuser[1:0];
            item_reg.last_cell     <= s_tlast;
            item_reg.last_module   <= s_tuser[2];
            item_reg.stop_in       <= s_tuser[3];
        end
        if (advance && item_reg.last_cell)
        begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.pack_max, res_reg.pack_min, res_reg.module_max,
                       res_reg.module_min, res_reg.module_index};
    assign m_tlast  = res_reg.pack_done;
    assign m_tuser  = {res_reg.shutdown, res_reg.pack_error};

    // A held cell stays in the input register until it moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("input register lost or changed a held cell");

    // A module end that cannot be delivered must not advance the statistics.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.last_cell |-> out_space)
        else $error("module result advanced while result register was full");

    // Every module has at least one cell, so its min never exceeds its max.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.module_min <= res_reg.module_max)
        else $error("module min above module max");

    // Pack fields are zero on results that do not end the pack.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.pack_done |->
            res_reg.pack_min == '0 && res_reg.pack_max == '0 &&
            !res_reg.pack_error && !res_reg.shutdown)
        else $error("pack fields set on a result without pack end");

    // Pack bounds are either ordered or still at their empty sentinels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.pack_done |->
            (res_reg.pack_min <= res_reg.pack_max) ||
            (res_reg.pack_min == bcmd_pkg::VOLT_MAX_VAL &&
             res_reg.pack_max == bcmd_pkg::VOLT_MIN_VAL))
        else $error("pack min/max inconsistent");

endmodule

### tb/battery_cell_minmax_diag_core_test.sv
// Self-checking testbench for the battery cell min/max diagnostics core.
module battery_cell_minmax_diag_core_test;

    localparam int MAX_MODULES = 16;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit          calm_tail;
    int unsigned cells_sent;

    battery_cell_minmax_diag_core #(
        .MAX_MODULES(MAX_MODULES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Tracks module and pack statistics and holds the reports still to come.
    class pack_stats_board;
        logic [7:0]        step_cfg;
        logic [7:0]        limit_cfg;
        logic [7:0]        timer;
        logic [15:0]       cell_lo;
        logic [15:0]       cell_hi;
        logic [15:0]       pack_lo;
        logic [15:0]       pack_hi;
        logic              pack_err;
        int unsigned       mod_count;
        bcmd_pkg::result_t pending_reports[$];
        int unsigned       bad;

        function new();
            bad = 0;
            step_cfg = bcmd_pkg::ERROR_STEP_RST;
            limit_cfg = bcmd_pkg::ERROR_LIMIT_RST;
            cell_lo = bcmd_pkg::VOLT_MAX_VAL;
            cell_hi = bcmd_pkg::VOLT_MIN_VAL;
            timer = '0;
            clear_pack();
        endfunction

        function void clear_pack();
            pack_lo = bcmd_pkg::VOLT_MAX_VAL;
            pack_hi = bcmd_pkg::VOLT_MIN_VAL;
            pack_err = 1'b0;
            mod_count = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [7:0] val);
            if (idx == bcmd_pkg::REG_ERROR_STEP)
                step_cfg = val;
            else
                limit_cfg = val;
        endfunction

        function void take_cell(bcmd_pkg::item_t it);
            bcmd_pkg::result_t r;
            logic [8:0]        sum;
            if (it.cell_voltage < cell_lo)
                cell_lo = it.cell_voltage;
            if (it.cell_voltage > cell_hi)
                cell_hi = it.cell_voltage;
            if (!it.last_cell)
                return;
            r = '0;
            r.module_index = mod_count[3:0];
            r.module_min = cell_lo;
            r.module_max = cell_hi;
            // Only the status that comes with the last cell decides the module.
            if (it.module_status == bcmd_pkg::STATUS_FLAWLESS)
            begin
                if (cell_lo < pack_lo)
                    pack_lo = cell_lo;
                if (cell_hi > pack_hi)
                    pack_hi = cell_hi;
            end
            else if (it.module_status == bcmd_pkg::STATUS_ERROR)
            begin
                pack_err = 1'b1;
            end
            cell_lo = bcmd_pkg::VOLT_MAX_VAL;
            cell_hi = bcmd_pkg::VOLT_MIN_VAL;
            if (it.last_module)
            begin
                if (!pack_err)
                begin
                    timer = '0;
                end
                else
                begin
                    sum = {1'b0, timer} + {1'b0, step_cfg};
                    timer = (sum > {1'b0, limit_cfg}) ? limit_cfg : sum[7:0];
                end
                r.pack_done = 1'b1;
                r.pack_min = pack_lo;
                r.pack_max = pack_hi;
                r.pack_error = pack_err;
                r.shutdown = it.stop_in | (timer >= limit_cfg);
                clear_pack();
            end
            else
            begin
                mod_count++;
                if (mod_count >= MAX_MODULES)
                    mod_count = 0;
            end
            pending_reports.push_back(r);
        endfunction

        function void match_report(bcmd_pkg::result_t got);
            bcmd_pkg::result_t want;
            bit                wrong;
            if (pending_reports.size() == 0)
            begin
                bad++;
                if (bad <= 10)
                    $display({"ERROR: report with none expected: ",
                              "idx=%0d min=%h max=%h done=%b"},
                             got.module_index, got.module_min, got.module_max, got.pack_done);
                return;
            end
            want = pending_reports.pop_front();
            wrong = (got.module_index !== want.module_index)
                 || (got.module_min !== want.module_min)
                 || (got.module_max !== want.module_max)
                 || (got.pack_done !== want.pack_done)
                 || (got.pack_min !== want.pack_min)
                 || (got.pack_max !== want.pack_max)
                 || (got.pack_error !== want.pack_error)
                 || (got.shutdown !== want.shutdown);
            if (wrong)
            begin
                bad++;
                if (bad <= 10)
                begin
                    $display({"ERROR: expected idx=%0d min=%h max=%h done=%b ",
                              "pmin=%h pmax=%h err=%b stop=%b"},
                             want.module_index, want.module_min, want.module_max,
                             want.pack_done, want.pack_min, want.pack_max,
                             want.pack_error, want.shutdown);
                    $display({"       actual   idx=%0d min=%h max=%h done=%b ",
                              "pmin=%h pmax=%h err=%b stop=%b"},
                             got.module_index, got.module_min, got.module_max,
                             got.pack_done, got.pack_min, got.pack_max,
                             got.pack_error, got.shutdown);
                end
            end
        endfunction
    endclass

    pack_stats_board board;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // Both streams are observed at the rising edge; inputs only move at the falling edge.
    always @(posedge clk)
    begin
        bcmd_pkg::item_t   seen;
        bcmd_pkg::result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                seen.cell_voltage = s_tdata;
                seen.module_status = s_tuser[1:0];
                seen.last_module = s_tuser[2];
                seen.stop_in = s_tuser[3];
                seen.last_cell = s_tlast;
                board.take_cell(seen);
            end
            if (m_tvalid && m_tready)
            begin
                got.module_index = m_tdata[3:0];
                got.module_min = m_tdata[19:4];
                got.module_max = m_tdata[35:20];
                got.pack_min = m_tdata[51:36];
                got.pack_max = m_tdata[67:52];
                got.pack_done = m_tlast;
                got.pack_error = m_tuser[0];
                got.shutdown = m_tuser[1];
                board.match_report(got);
            end
        end
    end

    // Receiver: ready most of the time, with stall bursts of random length.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!calm_tail && $urandom_range(0, 9) == 0)
            begin
                m_tready = 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_cell(bcmd_pkg::item_t it);
        int gap;
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = it.cell_voltage;
        s_tlast = it.last_cell;
        s_tuser = {it.stop_in, it.last_module, it.module_status};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        cells_sent++;
    endtask

    task automatic send_fields(logic [15:0] v, bcmd_pkg::module_status_t st,
                               bit lc, bit lm, bit sp);
        bcmd_pkg::item_t it;
        it.cell_voltage = v;
        it.module_status = st;
        it.last_cell = lc;
        it.last_module = lm;
        it.stop_in = sp;
        send_cell(it);
    endtask

    // Holds the sender off until every expected report has arrived.
    task automatic drain();
        s_tvalid = 1'b0;
        while (board.pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(logic [0:0] idx, logic [7:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = ($urandom & 32'hFFFF_FF00) | {24'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(logic [7:0] step, logic [7:0] limit);
        drain();
        reg_write(bcmd_pkg::REG_ERROR_STEP, step);
        reg_write(bcmd_pkg::REG_ERROR_LIMIT, limit);
    endtask

    function automatic logic [15:0] pick_volt();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 16'($urandom);
        else if (sel == 4)
            return bcmd_pkg::VOLT_MAX_VAL;
        else if (sel == 5)
            return bcmd_pkg::VOLT_MIN_VAL;
        else
            return 16'h8000 ^ 16'($urandom_range(0, 511));
    endfunction

    // One pack of well-formed modules with random content; err_pct biases the statuses.
    task automatic send_pack(int n_mod, int err_pct);
        bcmd_pkg::item_t it;
        int              n_cell;
        int              r;
        logic [1:0]      st;
        for (int m = 0; m < n_mod; m++)
        begin
            n_cell = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            r = $urandom_range(0, 99);
            if (r < err_pct)
                st = bcmd_pkg::STATUS_ERROR;
            else if (r < err_pct + 15)
                st = ($urandom_range(0, 1) == 0) ? bcmd_pkg::STATUS_EXCL_A
                                                 : bcmd_pkg::STATUS_EXCL_B;
            else
                st = bcmd_pkg::STATUS_FLAWLESS;
            for (int c = 0; c < n_cell; c++)
            begin
                it.cell_voltage = pick_volt();
                it.last_cell = (c == n_cell - 1);
                it.module_status = it.last_cell ? st : 2'($urandom_range(0, 3));
                it.last_module = it.last_cell ? (m == n_mod - 1) : 1'($urandom_range(0, 1));
                it.stop_in = ($urandom_range(0, 3) == 0);
                send_cell(it);
            end
        end
    endtask

    task automatic random_traffic(int unsigned count, int err_pct);
        int unsigned stop_at;
        int          r;
        stop_at = cells_sent + count;
        while (cells_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                drain();
            if (r < 8)
                send_pack($urandom_range(16, 19), err_pct);
            else if (r < 14)
                send_fields(pick_volt(), bcmd_pkg::module_status_t'($urandom_range(0, 3)),
                            1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_pack($urandom_range(1, 6), err_pct);
        end
    endtask

    initial
    begin
        board = new();
        calm_tail = 1'b0;
        cells_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset settings.
        send_fields(16'h0000, bcmd_pkg::STATUS_FLAWLESS, 1'b1, 1'b1, 1'b0);
        // A last-module flag without a last cell is ignored; only the final status counts.
        send_fields(16'hFFFF, bcmd_pkg::STATUS_ERROR, 1'b0, 1'b1, 1'b1);
        send_fields(16'h1234, bcmd_pkg::STATUS_FLAWLESS, 1'b1, 1'b0, 1'b0);
        send_fields(16'h0000, bcmd_pkg::STATUS_EXCL_A, 1'b1, 1'b0, 1'b0);
        send_fields(16'h0001, bcmd_pkg::STATUS_EXCL_B, 1'b1, 1'b1, 1'b1);
        // A pack with no flawless module keeps the sentinels.
        send_fields(16'd100, bcmd_pkg::STATUS_ERROR, 1'b1, 1'b1, 1'b0);
        send_fields(16'd500, bcmd_pkg::STATUS_FLAWLESS, 1'b0, 1'b0, 1'b0);
        send_fields(16'd400, bcmd_pkg::STATUS_ERROR, 1'b1, 1'b0, 1'b0);
        send_fields(16'd300, bcmd_pkg::STATUS_FLAWLESS, 1'b1, 1'b1, 1'b0);
        send_fields(16'hFFFF, bcmd_pkg::STATUS_FLAWLESS, 1'b0, 1'b0, 1'b0);
        send_fields(16'hFFFF, bcmd_pkg::STATUS_FLAWLESS, 1'b1, 1'b1, 1'b1);
        send_fields(16'h0000, bcmd_pkg::STATUS_EXCL_B, 1'b0, 1'b0, 1'b1);
        send_fields(16'h0000, bcmd_pkg::STATUS_ERROR, 1'b1, 1'b0, 1'b1);
        send_fields(16'h8000, bcmd_pkg::STATUS_EXCL_A, 1'b1, 1'b1, 1'b0);
        drain();
        random_traffic(250, 25);

        // Extremes of both registers: one error pack saturates the timer.
        set_config(8'd255, 8'd255);
        random_traffic(150, 25);

        // A zero limit means emergency stop at every pack end.
        set_config(8'd0, 8'd0);
        random_traffic(150, 25);

        // Drive the timer to its limit, then lower the limit below it.
        set_config(8'd60, 8'd200);
        repeat (4)
            send_fields(16'($urandom), bcmd_pkg::STATUS_ERROR, 1'b1, 1'b1, 1'b0);
        set_config(8'd60, 8'd30);
        send_fields(16'($urandom), bcmd_pkg::STATUS_ERROR, 1'b1, 1'b1, 1'b0);
        send_fields(16'($urandom), bcmd_pkg::STATUS_FLAWLESS, 1'b1, 1'b1, 1'b0);
        set_config(8'($urandom_range(1, 40)), 8'($urandom_range(20, 120)));
        random_traffic(150, 40);

        // Last part runs at full rate on both sides.
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        calm_tail = 1'b1;
        random_traffic(200, 25);

        drain();
        repeat (10) @(negedge clk);
        if (board.bad == 0 && board.pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
design/bcmd_pkg.sv
design/bcmd_cfg.sv
design/bcmd_datapath.sv
design/battery_cell_minmax_diag_core.sv
tb/battery_cell_minmax_diag_core_test.sv
